/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files of this project.
// Every property is sampled on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

/* rtl/cep_pkg.sv */
// Package for the cursor editor with prefix maxima: sizes, command codes and the
// control and status structs between the controller and the datapath. No dependencies.
package cep_pkg;

   localparam int DEPTH      = 4096;
   localparam int VALUE_BITS = 16;
   localparam int SUM_W      = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CMD_W      = 3;
   localparam int REQ_DATA_W = ((VALUE_BITS + CNT_W + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_DELETE = 3'd1,
      CMD_LEFT   = 3'd2,
      CMD_RIGHT  = 3'd3,
      CMD_QUERY  = 3'd4
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;            // capture the word and read the stack tops
      logic push;            // push onto the left stack
      logic push_from_right; // pushed value comes from the right stack top
      logic drop_left;       // left count down by one
      logic move_to_right;   // write the left top onto the right stack
      logic pop_right;       // right count down by one
      logic respond;         // load the result register
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cmd_type cmd;
      logic    left_empty;
      logic    left_full;
      logic    right_empty;
      logic    right_full;
      logic    has_room;
      logic    rsp_busy;
   } stat_type;

endpackage

/* rtl/cep_controller.sv */
// Controller state machine of the cursor editor: accepts a word, then issues the
// update commands for it in ST_EXEC, where a query may wait. Depends on cep_pkg.
module cep_controller import cep_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output ctl_type  ctl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            case (stat.cmd)
               CMD_INSERT: begin
                  ctl.push = stat.has_room;
               end
               CMD_DELETE: begin
                  ctl.drop_left = !stat.left_empty;
               end
               CMD_LEFT: begin
                  if (!stat.left_empty && !stat.right_full) begin
                     ctl.move_to_right = 1'b1;
                     ctl.drop_left     = 1'b1;
                  end
               end
               CMD_RIGHT: begin
                  if (!stat.right_empty && !stat.left_full) begin
                     ctl.push            = 1'b1;
                     ctl.push_from_right = 1'b1;
                     ctl.pop_right       = 1'b1;
                  end
               end
               CMD_QUERY: begin
                  // Hold here until the result register is free.
                  if (stat.rsp_busy) begin
                     state_in = ST_EXEC;
                  end else begin
                     ctl.respond = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/cep_datapath.sv */
// Datapath of the cursor editor: the two stacks and prefix tables in synchronous
// memories, the counts, the prefix adder and the result register. Depends on cep_pkg.
module cep_datapath import cep_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]      req_tuser,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [SUM_W-1:0]      rsp_tdata,
   output logic                  rsp_tuser,
   input  ctl_type               ctl,
   output stat_type              stat
);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   logic [VALUE_BITS-1:0] lval_mem [DEPTH];
   logic [SUM_W-1:0]      lsum_mem [DEPTH];
   logic [SUM_W-1:0]      lmax_mem [DEPTH];
   logic [VALUE_BITS-1:0] rval_mem [DEPTH];

   cmd_type               cmd_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [CNT_W-1:0]      qlen_ff;
   logic [CNT_W-1:0]      lc_ff, lc_in;
   logic [CNT_W-1:0]      rc_ff, rc_in;
   logic [VALUE_BITS-1:0] lval_rd_ff, rval_rd_ff;
   logic [SUM_W-1:0]      lsum_rd_ff, lmax_rd_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]      rsp_data_ff;
   logic                  rsp_err_ff;

   logic [CNT_W-1:0]      qlen_req, qlen_m1, lc_m1, rc_m1;
   logic [ADDR_W-1:0]     left_rd_addr;
   logic [VALUE_BITS-1:0] push_val;
   logic signed [SUM_W:0] prev_sum, push_ext, sum_wide;
   logic [SUM_W-1:0]      new_sum, new_max;
   logic                  query_err;

   assign qlen_req = req_tdata[VALUE_BITS +: CNT_W];
   assign qlen_m1  = qlen_req - CNT_W'(1);
   assign lc_m1    = lc_ff - CNT_W'(1);
   assign rc_m1    = rc_ff - CNT_W'(1);

   // A query reads its prefix entry, every other command reads the entry below the cursor.
   assign left_rd_addr = (req_tuser == CMD_QUERY) ? qlen_m1[ADDR_W-1:0] : lc_m1[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff     <= cmd_type'(req_tuser);
         value_ff   <= req_tdata[VALUE_BITS-1:0];
         qlen_ff    <= qlen_req;
         lval_rd_ff <= lval_mem[left_rd_addr];
         lsum_rd_ff <= lsum_mem[left_rd_addr];
         lmax_rd_ff <= lmax_mem[left_rd_addr];
         rval_rd_ff <= rval_mem[rc_m1[ADDR_W-1:0]];
      end
   end

   assign push_val = ctl.push_from_right ? rval_rd_ff : value_ff;
   assign prev_sum = (lc_ff == '0) ? '0 : {lsum_rd_ff[SUM_W-1], lsum_rd_ff};
   assign push_ext = {{(SUM_W + 1 - VALUE_BITS){push_val[VALUE_BITS-1]}}, push_val};
   assign sum_wide = prev_sum + push_ext;

   // The top two bits differ only when the sum left the 32-bit range.
   always_comb begin
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         new_sum = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         new_sum = sum_wide[SUM_W-1:0];
      end
      if (lc_ff == '0 || $signed(new_sum) > $signed(lmax_rd_ff)) begin
         new_max = new_sum;
      end else begin
         new_max = lmax_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         lval_mem[lc_ff[ADDR_W-1:0]] <= push_val;
         lsum_mem[lc_ff[ADDR_W-1:0]] <= new_sum;
         lmax_mem[lc_ff[ADDR_W-1:0]] <= new_max;
      end
      if (ctl.move_to_right) begin
         rval_mem[rc_ff[ADDR_W-1:0]] <= lval_rd_ff;
      end
   end

   always_comb begin
      lc_in = lc_ff;
      rc_in = rc_ff;
      if (ctl.push) begin
         lc_in = lc_ff + CNT_W'(1);
      end else if (ctl.drop_left) begin
         lc_in = lc_m1;
      end
      if (ctl.move_to_right) begin
         rc_in = rc_ff + CNT_W'(1);
      end else if (ctl.pop_right) begin
         rc_in = rc_m1;
      end
   end

   assign query_err = (qlen_ff == '0) || (qlen_ff > lc_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.respond) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lc_ff        <= '0;
         rc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lc_ff        <= lc_in;
         rc_ff        <= rc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.respond) begin
         rsp_data_ff <= query_err ? '0 : lmax_rd_ff;
         rsp_err_ff  <= query_err;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

   assign stat.cmd         = cmd_ff;
   assign stat.left_empty  = (lc_ff == '0);
   assign stat.left_full   = (lc_ff == DEPTH_CNT);
   assign stat.right_empty = (rc_ff == '0);
   assign stat.right_full  = (rc_ff == DEPTH_CNT);
   assign stat.has_room    = ({1'b0, lc_ff} + {1'b0, rc_ff}) < {1'b0, DEPTH_CNT};
   assign stat.rsp_busy    = rsp_valid_ff && !rsp_tready;

endmodule

/* rtl/cursor_editor_prefix_max_top.sv */
// Top level of the cursor editor with prefix maxima: controller plus datapath.
// Depends on cep_pkg, cep_controller and cep_datapath.
//
// A sequence editor built as two stacks around a cursor, holding for every element left of
// the cursor its prefix sum and the running maximum of the prefix sums. In the cycle a word is
// accepted the stack tops (or, for a query, the prefix entry) are read from single-port
// synchronous memories, and in the next cycle the update is written back and the counts
// change. A query whose result register is still occupied waits in ST_EXEC until the
// result is taken; the result register lets a new word enter while a result is still
// waiting. Only a query gives a result: the largest prefix sum over the first query_len
// elements, or query_error with zero data when query_len is zero or greater than the
// number of elements left of the cursor. Delete or move at an empty side is ignored,
// insert with the store full is dropped, and unused command codes do nothing. The memories
// are not cleared after reset; only the counts are, and nothing beyond them is used.
module cursor_editor_prefix_max_top import cep_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // value[15:0], query_len[28:16], zero fill
   input  logic [CMD_W-1:0]      req_tuser,  // cmd[2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SUM_W-1:0]      rsp_tdata,  // max_prefix[31:0]
   output logic                  rsp_tuser   // query_error[0]
);

   ctl_type  ctl;
   stat_type stat;

   cep_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   cep_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .ctl        (ctl),
      .stat       (stat)
   );

endmodule

/* rtl/cep_checker.sv */
// Port-level checks for the cursor editor top level, attached by a bind statement.
// Depends on cep_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cep_checker import cep_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [CMD_W-1:0]      req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [SUM_W-1:0]      rsp_tdata,
   input logic                  rsp_tuser
);

   logic req_fire, zero_query;

   assign req_fire   = req_tvalid && req_tready;
   assign zero_query = req_fire && (req_tuser == CMD_QUERY)
                       && (req_tdata[VALUE_BITS +: CNT_W] == '0) && !rsp_tvalid;

   // A result word that is not taken stays unchanged.
   `ASSERT_CLK(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result word changed while stalled")
   // An error result carries zero data.
   `ASSERT_NEVER(a_err_zero, rsp_tvalid && rsp_tuser && (rsp_tdata != '0), "error result with nonzero data")
   // The block works on one word at a time.
   `ASSERT_CLK(a_one_at_a_time, req_fire |=> !req_tready, "word accepted while the previous one is in work")
   // A query of zero length accepted while no result is waiting answers with an error.
   `ASSERT_CLK(a_zero_query, zero_query |=> ##1 (rsp_tvalid && rsp_tuser), "zero-length query gave no error result")

endmodule

bind cursor_editor_prefix_max_top cep_checker u_cep_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* sim/testbench.sv */
// Testbench for cursor_editor_prefix_max_top: drives command words with random gaps, predicts
// every query answer with a behavioral copy of the two-stack editor and checks each result word.
// Depends on cep_pkg and the RTL of cursor_editor_prefix_max_top.
`timescale 1ns / 100ps

module testbench;
   import cep_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 400;
   localparam int RANDOM_WORDS   = 900;
   localparam int DRAIN_CYCLES   = 16;

   typedef struct {
      logic signed [SUM_W-1:0] max_prefix;
      logic                    query_error;
   } answer_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = CMD_INSERT;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [SUM_W-1:0]      rsp_tdata;
   logic                  rsp_tuser;

   // Behavioral copy of the editor state.
   logic signed [VALUE_BITS-1:0] left_vals  [DEPTH];
   logic signed [SUM_W-1:0]      left_sums  [DEPTH];
   logic signed [SUM_W-1:0]      left_maxes [DEPTH];
   logic signed [VALUE_BITS-1:0] right_vals [DEPTH];
   int                           left_cnt  = 0;
   int                           right_cnt = 0;

   answer_type pending_answers[$];
   int      error_count   = 0;
   bit      send_gaps     = 1'b1;
   bit      ready_stalls  = 1'b1;
   bit      hold_request  = 1'b0;

   cursor_editor_prefix_max_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      else if (r < 92) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   function automatic void push_left_stack(logic signed [VALUE_BITS-1:0] v);
      longint sum;
      logic signed [SUM_W-1:0] sum32;
      sum = (left_cnt == 0) ? 0 : longint'(left_sums[left_cnt-1]);
      sum = sum + longint'(v);
      if (sum > longint'(32'sh7fffffff)) sum = longint'(32'sh7fffffff);
      if (sum < -longint'(64'h80000000)) sum = -longint'(64'h80000000);
      sum32 = sum[SUM_W-1:0];
      left_vals[left_cnt] = v;
      left_sums[left_cnt] = sum32;
      if (left_cnt == 0 || sum32 > left_maxes[left_cnt-1])
         left_maxes[left_cnt] = sum32;
      else
         left_maxes[left_cnt] = left_maxes[left_cnt-1];
      left_cnt++;
   endfunction

   // Applies one accepted word to the editor copy and queues the answer a query gives.
   function automatic void editor_apply(logic [CMD_W-1:0] cmd, logic signed [VALUE_BITS-1:0] value,
                                        logic [CNT_W-1:0] qlen);
      answer_type ans;
      case (cmd)
         CMD_INSERT: begin
            if (left_cnt + right_cnt < DEPTH) push_left_stack(value);
         end
         CMD_DELETE: begin
            if (left_cnt > 0) left_cnt--;
         end
         CMD_LEFT: begin
            if (left_cnt > 0 && right_cnt < DEPTH) begin
               right_vals[right_cnt] = left_vals[left_cnt-1];
               right_cnt++;
               left_cnt--;
            end
         end
         CMD_RIGHT: begin
            if (right_cnt > 0 && left_cnt < DEPTH) begin
               right_cnt--;
               push_left_stack(right_vals[right_cnt]);
            end
         end
         CMD_QUERY: begin
            if (qlen == 0 || int'(qlen) > left_cnt) begin
               ans.max_prefix  = '0;
               ans.query_error = 1'b1;
            end else begin
               ans.max_prefix  = left_maxes[qlen-1];
               ans.query_error = 1'b0;
            end
            pending_answers.push_back(ans);
         end
         default: ;
      endcase
   endfunction

   // Offers one word, after a random gap when gaps are enabled, and waits for it to be taken.
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VALUE_BITS-1:0] value,
                            input logic [CNT_W-1:0] qlen);
      int gap;
      gap = send_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_DATA_W-VALUE_BITS-CNT_W){1'b0}}, qlen, value};
      do @(posedge clock); while (!req_tready);
      editor_apply(cmd, value, qlen);
   endtask

   // Stops offering words and waits until every expected result has been taken.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   function automatic logic [VALUE_BITS-1:0] random_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return {1'b0, {(VALUE_BITS-1){1'b1}}};
      else if (r == 1) return {1'b1, {(VALUE_BITS-1){1'b0}}};
      else return VALUE_BITS'($urandom());
   endfunction

   function automatic logic [CNT_W-1:0] random_query_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return CNT_W'($urandom_range(1, (left_cnt > 0) ? left_cnt : 1));
      else if (r < 80) return '0;
      else if (r < 90) return CNT_W'(left_cnt + 1);
      else return CNT_W'($urandom());
   endfunction

   // Empty sides, extreme values, every command, out-of-range queries and unused codes.
   task automatic test_corner_cases();
      send_word(CMD_DELETE, '0, '0);
      send_word(CMD_LEFT,   '0, '0);
      send_word(CMD_RIGHT,  '0, '0);
      send_word(CMD_QUERY,  '0, '0);
      send_word(CMD_QUERY,  '0, 1);
      send_word(CMD_INSERT, 16'h7fff, '0);
      send_word(CMD_INSERT, 16'h8000, '0);
      send_word(CMD_INSERT, 16'h0000, '1);
      send_word(CMD_INSERT, 16'hffff, '0);
      send_word(CMD_QUERY,  '0, 1);
      send_word(CMD_QUERY,  '0, 2);
      send_word(CMD_QUERY,  '0, 4);
      send_word(CMD_QUERY,  '0, 5);
      send_word(CMD_QUERY,  '1, '1);
      send_word(CMD_LEFT,   '1, '0);
      send_word(CMD_LEFT,   '0, '0);
      send_word(CMD_QUERY,  '0, 2);
      send_word(CMD_QUERY,  '0, 3);
      send_word(CMD_RIGHT,  '0, '0);
      send_word(CMD_QUERY,  '0, 3);
      send_word(CMD_DELETE, '0, '0);
      send_word(CMD_QUERY,  '0, 3);
      send_word(CMD_W'(CMD_QUERY + 1), 16'h1234, 2);
      send_word({CMD_W{1'b1}}, 16'h4321, 1);
      send_word(CMD_QUERY,  '0, 2);
   endtask

   task automatic test_random_edits();
      int done;
      int r;
      logic [CMD_W-1:0] cmd;
      done = 0;
      while (done < RANDOM_WORDS) begin
         // A middle stretch runs with no idling on either side.
         send_gaps    = !(done >= 300 && done < 450);
         ready_stalls = send_gaps;
         r = $urandom_range(0, 99);
         if (r < 35) cmd = CMD_INSERT;
         else if (r < 47) cmd = CMD_DELETE;
         else if (r < 62) cmd = CMD_LEFT;
         else if (r < 77) cmd = CMD_RIGHT;
         else if (r < 97) cmd = CMD_QUERY;
         else cmd = CMD_W'($urandom_range(CMD_QUERY + 1, {CMD_W{1'b1}}));
         if (cmd == CMD_QUERY)
            send_word(cmd, VALUE_BITS'($urandom()), random_query_len());
         else
            send_word(cmd, random_value(), CNT_W'($urandom()));
         if (cmd <= CMD_QUERY) done++;
      end
      send_gaps    = 1'b1;
      ready_stalls = 1'b1;
   endtask

   // The receiver holds off while queries keep coming, so the input backs up.
   task automatic test_output_backpressure();
      hold_request = 1'b1;
      send_gaps    = 1'b0;
      for (int i = 0; i < 16; i++) begin
         if (i % 3 == 0)
            send_word(CMD_INSERT, random_value(), '0);
         else
            send_word(CMD_QUERY, '0, random_query_len());
      end
      send_gaps = 1'b1;
      wait_drained();
   endtask

   // Fill the store completely, check the dropped insert and queries at the full length.
   task automatic test_full_store();
      send_gaps    = 1'b0;
      ready_stalls = 1'b0;
      while (left_cnt + right_cnt < DEPTH)
         send_word(CMD_INSERT, ($urandom_range(0, 3) == 0) ? random_value() : 16'h7fff, '0);
      send_word(CMD_INSERT, 16'h8000, '0);
      while (right_cnt > 0) send_word(CMD_RIGHT, '0, '0);
      send_gaps    = 1'b1;
      ready_stalls = 1'b1;
      send_word(CMD_QUERY,  '0, CNT_W'(DEPTH));
      send_word(CMD_QUERY,  '0, CNT_W'(DEPTH + 1));
      send_word(CMD_INSERT, 16'h8000, '0);
      send_word(CMD_QUERY,  '0, CNT_W'(DEPTH));
      send_word(CMD_LEFT,   '0, '0);
      send_word(CMD_QUERY,  '0, CNT_W'(DEPTH));
      send_word(CMD_INSERT, 16'h8000, '0);
      send_word(CMD_QUERY,  '0, CNT_W'(DEPTH));
      for (int i = 0; i < 20; i++) send_word(CMD_QUERY, '0, random_query_len());
      send_word(CMD_DELETE, '0, '0);
      send_word(CMD_QUERY,  '0, CNT_W'(DEPTH));
   endtask

   // Receiver: random stalls, plus one long hold-off on request.
   always begin
      @(posedge clock);
      if (hold_request) begin
         rsp_tready <= 1'b0;
         repeat (LONG_HOLD) @(posedge clock);
         hold_request = 1'b0;
      end else if (ready_stalls && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         repeat (pick_gap() + 1) @(posedge clock);
      end
      rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin : check_results
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected result word: max_prefix %0d query_error %0b",
                   $signed(rsp_tdata), rsp_tuser);
            error_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata !== want.max_prefix) begin
               $error("max_prefix: expected %0d, got %0d", want.max_prefix, $signed(rsp_tdata));
               error_count++;
            end
            if (rsp_tuser !== want.query_error) begin
               $error("query_error: expected %0b, got %0b", want.query_error, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle = 0;
         else
            idle++;
      end
      $display("cursor_editor_prefix_max_top verification failed");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_corner_cases();
      test_random_edits();
      test_output_backpressure();
      test_full_store();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("cursor_editor_prefix_max_top verification clean");
      else
         $display("cursor_editor_prefix_max_top verification failed");
      $finish;
   end

endmodule
